### hw/rtl/quad_encoder_attenuator_control_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef QUAD_ENCODER_ATTENUATOR_CONTROL_ASSERT_SVH
`define QUAD_ENCODER_ATTENUATOR_CONTROL_ASSERT_SVH

// Concurrent assertion on the block clock, off while reset is applied.
`define QEAC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qeac assertion failed");

// Same, for an implication written as antecedent and consequent.
`define QEAC_ASSERT_IMPL(label, ante, cons) \
  `QEAC_ASSERT(label, (ante) |-> (cons))

`endif

### hw/rtl/qeac_pkg.sv
package qeac_pkg;

  localparam int unsigned NumCh    = 4;
  localparam int unsigned AttW     = 5;
  localparam int unsigned WordW    = AttW + 1;
  localparam int unsigned GainW    = AttW + 1;
  localparam int unsigned InDataW  = 2 * NumCh;
  localparam int unsigned OutDataW = NumCh * (WordW + GainW);

  localparam logic [AttW-1:0] AttMin   = '0;
  localparam logic [AttW-1:0] AttMax   = '1;
  localparam logic [AttW-1:0] AttReset = AttW'(18);
  localparam logic [AttW-1:0] RefReset = AttW'(18);

  typedef logic [AttW-1:0] att_t;

endpackage

### hw/rtl/quad_encoder_attenuator_control.sv
// Attenuator control for four rotary encoders. Each request on the slave
// stream is one scan sample: tdata[3:0] holds the A lines and tdata[7:4] the
// B lines, bit n of each belonging to encoder n. A fall of an A line from one
// sample to the next is a detent; B high then lowers that channel's
// attenuation by one and B low raises it, saturating at 0 and 31. Only one
// channel steps per sample, the highest-numbered one with a detent, while the
// A history of all four channels is always updated. Every sample produces
// exactly one result on the master stream carrying, per channel, a 6-bit
// serial word (inverted attenuation in bits 5..1, bit 0 zero) and a signed
// gain equal to the gain reference minus the attenuation. Attenuations reset
// to 18 and the gain reference resets to 18; the user must write the reference
// through cfg_we_i/cfg_wdata_i only while the streams are idle, which the block
// itself does not enforce. The block takes one sample per clock unless the
// master side stalls: the update is a single pass of logic into one output
// register, and a new sample is taken whenever that register is empty or is
// drained in the same cycle, so the result follows in the next cycle.
module quad_encoder_attenuator_control (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Gain reference register, written whenever cfg_we_i is high.
  input  logic                           cfg_we_i,
  input  logic [qeac_pkg::AttW-1:0]      cfg_wdata_i,
  // Scan samples.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, lowest bit up: enc_a_lines[3:0], enc_b_lines[3:0]
  input  logic [qeac_pkg::InDataW-1:0]   s_axis_tdata,
  // Results.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata, lowest bit up: spi_word_0..3 (6 bits each), then gain_0..3
  // (6 bits each, two's complement)
  output logic [qeac_pkg::OutDataW-1:0]  m_axis_tdata
);
  import qeac_pkg::*;

  logic [AttW-1:0]     gain_ref_q;
  logic [NumCh-1:0]    a_hist_q;
  att_t                att_q [NumCh];
  att_t                att_d [NumCh];
  logic                out_valid_q, out_valid_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [NumCh-1:0]    a_lines, b_lines;
  logic [NumCh-1:0]    detent;
  logic [NumCh-1:0]    win_oh;
  logic                in_accept;

  assign a_lines = s_axis_tdata[NumCh-1:0];
  assign b_lines = s_axis_tdata[2*NumCh-1:NumCh];

  // The output register is free when empty or when its result leaves now.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // A falling A line is a detent.
  assign detent = a_hist_q & ~a_lines;

  // Later channels override earlier ones, so the highest detent wins.
  always_comb begin
    win_oh = '0;
    for (int ch = 0; ch < NumCh; ch++) begin
      if (detent[ch]) begin
        win_oh     = '0;
        win_oh[ch] = 1'b1;
      end
    end
  end

  // Saturating step of the winning channel, and the packed result built from
  // the attenuations as they stand after this sample.
  always_comb begin
    for (int ch = 0; ch < NumCh; ch++) begin
      att_d[ch] = att_q[ch];
      if (win_oh[ch]) begin
        if (b_lines[ch]) begin
          if (att_q[ch] != AttMin) begin
            att_d[ch] = att_q[ch] - AttW'(1);
          end
        end else begin
          if (att_q[ch] != AttMax) begin
            att_d[ch] = att_q[ch] + AttW'(1);
          end
        end
      end
    end
    out_data_d = '0;
    for (int ch = 0; ch < NumCh; ch++) begin
      out_data_d[ch*WordW +: WordW] = {~att_d[ch], 1'b0};
      out_data_d[(NumCh*WordW + ch*GainW) +: GainW] =
        {1'b0, gain_ref_q} - {1'b0, att_d[ch]};
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_ref_q  <= RefReset;
      a_hist_q    <= '0;
      out_valid_q <= 1'b0;
      for (int ch = 0; ch < NumCh; ch++) begin
        att_q[ch] <= AttReset;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        gain_ref_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        a_hist_q <= a_lines;
        for (int ch = 0; ch < NumCh; ch++) begin
          att_q[ch] <= att_d[ch];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### hw/rtl/qeac_checker.sv
`include "quad_encoder_attenuator_control_assert.svh"

module qeac_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [qeac_pkg::OutDataW-1:0] m_axis_tdata
);
  import qeac_pkg::*;

  // A stalled result keeps its payload.
  `QEAC_ASSERT_IMPL(a_out_hold, m_axis_tvalid && !m_axis_tready,
                    ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
  // Every accepted request yields a result in the next cycle.
  `QEAC_ASSERT_IMPL(a_req_to_result, s_axis_tvalid && s_axis_tready, ##1 m_axis_tvalid)
  // No result appears without a request.
  `QEAC_ASSERT_IMPL(a_no_spurious, !m_axis_tvalid && !(s_axis_tvalid && s_axis_tready),
                    ##1 !m_axis_tvalid)
  // An empty output stage never stalls the input side.
  `QEAC_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind quad_encoder_attenuator_control qeac_checker u_qeac_checker (.*);
